### hw/rtl/prq_pkg.sv
// package for the priority ready queue: sizes, status codes and shared types
`default_nettype none

package prq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned ID_BITS    = 6;
  localparam int unsigned PRIO_BITS  = 8;
  localparam int unsigned IDX_BITS   = $clog2(DEPTH);
  localparam int unsigned COUNT_BITS = $clog2(DEPTH + 1);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } prq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } prq_status_e;

  // one held entry
  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } prq_entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                  enq;
    logic                  deq;
    prq_entry_t            item;
    logic [COUNT_BITS-1:0] count;
  } prq_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/prq_cell.sv
// one queue cell: holds an entry, shifts toward the tail on insert, toward the head on removal
`default_nettype none

module prq_cell
  import prq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic [IDX_BITS-1:0] idx_i,
  input  wire prq_cmd_t            cmd_i,
  input  wire logic                prev_keep_i,
  input  wire prq_entry_t          prev_data_i,
  input  wire prq_entry_t          next_data_i,
  output      logic                keep_o,
  output      prq_entry_t          data_o
);

  prq_entry_t data_q, data_d;
  logic       occupied;

  // cell holds a live entry when its index is below the fill count
  assign occupied = (COUNT_BITS'(idx_i) < cmd_i.count);
  // entry stays in place on insert when its priority is greater or equal
  assign keep_o   = occupied && (data_q.prio >= cmd_i.item.prio);
  assign data_o   = data_q;

  // next entry: take new item, take upstream entry, or pull from downstream
  always_comb begin
    data_d = data_q;
    if (cmd_i.enq && !keep_o) begin
      if (prev_keep_i) begin
        data_d = cmd_i.item;
      end else begin
        data_d = prev_data_i;
      end
    end else if (cmd_i.deq) begin
      data_d = next_data_i;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

`default_nettype wire

### hw/rtl/priority_ready_queue.sv
// Priority ready queue top level: a row of cells kept sorted by descending priority.
// The result of an item appears with done_o in the cycle after its start transfer.
// Throughput: one item per cycle; every cell compares and shifts in the same cycle.
// busy stays low, so start may be held high every cycle; the receiver cannot stall.
// Reset clears the fill count and the result strobe; cell contents are undefined until written.
`default_nettype none

module priority_ready_queue
  import prq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic                  opcode_i,
  input  wire logic [ID_BITS-1:0]    proc_id_i,
  input  wire logic [PRIO_BITS-1:0]  prio_i,
  output      logic                  done_o,
  output      logic [ID_BITS-1:0]    out_id_o,
  output      logic [PRIO_BITS-1:0]  out_prio_o,
  output      logic [1:0]            status_o,
  output      logic [COUNT_BITS-1:0] occupancy_o
);

  localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(DEPTH);

  logic                  take;
  logic                  is_full, is_empty;
  prq_cmd_t              cmd;
  logic [DEPTH-1:0]      keep;
  prq_entry_t            cell_data [DEPTH];
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  done_q;
  prq_entry_t            res_q, res_d;
  prq_status_e           status_q, status_d;

  assign busy = 1'b0;
  assign take = start && !busy;

  assign is_full  = (count_q == FULL_COUNT);
  assign is_empty = (count_q == '0);

  // command to the cell row
  always_comb begin
    cmd.enq       = take && (prq_op_e'(opcode_i) == OP_ENQ) && !is_full;
    cmd.deq       = take && (prq_op_e'(opcode_i) == OP_DEQ) && !is_empty;
    cmd.item.id   = proc_id_i;
    cmd.item.prio = prio_i;
    cmd.count     = count_q;
  end

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       prev_keep;
    prq_entry_t prev_data, next_data;
    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
      assign prev_data = cmd.item;
    end else begin : g_mid
      assign prev_keep = keep[i-1];
      assign prev_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_data = cell_data[i];
    end else begin : g_inner
      assign next_data = cell_data[i+1];
    end
    prq_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_BITS'(i)),
      .cmd_i       (cmd),
      .prev_keep_i (prev_keep),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .keep_o      (keep[i]),
      .data_o      (cell_data[i])
    );
  end

  // fill count and result
  always_comb begin
    count_d  = count_q;
    res_d    = '0;
    status_d = ST_OK;
    if (cmd.enq) begin
      count_d = count_q + COUNT_BITS'(1);
    end else if (cmd.deq) begin
      count_d = count_q - COUNT_BITS'(1);
      res_d   = cell_data[0];
    end else if (take && (prq_op_e'(opcode_i) == OP_ENQ)) begin
      status_d = ST_FULL;
    end else if (take) begin
      status_d = ST_EMPTY;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= take;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q    <= res_d;
      status_q <= status_d;
    end
  end

  assign done_o      = done_q;
  assign out_id_o    = res_q.id;
  assign out_prio_o  = res_q.prio;
  assign status_o    = status_q;
  assign occupancy_o = count_q;

endmodule

`default_nettype wire

### dv/tb_priority_ready_queue.sv
// testbench for the priority ready queue: directed table, then random traffic against a predictor
`default_nettype none

module tb_priority_ready_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import prq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 1880;
  localparam int unsigned REPORT_LIMIT = 10;

  // one result as seen on the output ports
  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [PRIO_BITS-1:0]  prio;
    prq_status_e           status;
    logic [COUNT_BITS-1:0] occ;
  } sched_result_t;

  // one row of the directed table
  typedef struct {
    prq_op_e              op;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    bit                   typed;
    sched_result_t        res;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  opcode_i = OP_ENQ;
  logic [ID_BITS-1:0]    proc_id_i = '0;
  logic [PRIO_BITS-1:0]  prio_i = '0;
  logic                  busy;
  logic                  done_o;
  logic [ID_BITS-1:0]    out_id_o;
  logic [PRIO_BITS-1:0]  out_prio_o;
  logic [1:0]            status_o;
  logic [COUNT_BITS-1:0] occupancy_o;

  // predictor state: held entries, head at index 0
  logic [ID_BITS-1:0]    held_id [DEPTH];
  logic [PRIO_BITS-1:0]  held_prio [DEPTH];
  int                    held_count = 0;

  sched_result_t         pending_results [$];
  dir_row_t              dir_rows [$];
  int                    err_count = 0;
  int                    cycle_count = 0;
  int                    gap_pct = 0;

  priority_ready_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .proc_id_i   (proc_id_i),
    .prio_i      (prio_i),
    .done_o      (done_o),
    .out_id_o    (out_id_o),
    .out_prio_o  (out_prio_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("priority_ready_queue verification failed");
      $finish;
    end
  end

  // sorted insert behind equal priorities, remove from head
  function automatic sched_result_t apply_queue_op(prq_op_e op, logic [ID_BITS-1:0] id,
                                                   logic [PRIO_BITS-1:0] pr);
    sched_result_t res;
    int pos;
    res = '{id: '0, prio: '0, status: ST_OK, occ: '0};
    if (op == OP_ENQ) begin
      if (held_count == DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_prio[pos] >= pr) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_id[i]   = held_id[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_id[pos]   = id;
        held_prio[pos] = pr;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.id   = held_id[0];
      res.prio = held_prio[0];
      for (int i = 1; i < held_count; i++) begin
        held_id[i-1]   = held_id[i];
        held_prio[i-1] = held_prio[i];
      end
      held_count--;
    end
    res.occ = COUNT_BITS'(held_count);
    return res;
  endfunction

  function automatic dir_row_t dir_row(prq_op_e op, int id, int pr, bit typed = 1'b0,
                                       sched_result_t res = '0);
    dir_row_t r;
    r.op    = op;
    r.id    = ID_BITS'(id);
    r.prio  = PRIO_BITS'(pr);
    r.typed = typed;
    r.res   = res;
    return r;
  endfunction

  // one start transfer with optional idle cycles before it
  task automatic send_item(prq_op_e op, logic [ID_BITS-1:0] id, logic [PRIO_BITS-1:0] pr,
                           bit typed, sched_result_t typed_res);
    sched_result_t predicted;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    start     <= 1'b1;
    opcode_i  <= op;
    proc_id_i <= id;
    prio_i    <= pr;
    do @(posedge clk_i); while (busy);
    predicted = apply_queue_op(op, id, pr);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic report_mismatch(string what, sched_result_t exp_res, sched_result_t got);
    if (err_count < REPORT_LIMIT)
      $display("%s: exp id %0d prio %0d st %0d occ %0d, got id %0d prio %0d st %0d occ %0d",
               what, exp_res.id, exp_res.prio, exp_res.status, exp_res.occ,
               got.id, got.prio, got.status, got.occ);
    err_count++;
  endtask

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    sched_result_t got;
    sched_result_t exp_res;
    if (rst_ni && done_o === 1'b1) begin
      got = '{id: out_id_o, prio: out_prio_o, status: prq_status_e'(status_o),
              occ: occupancy_o};
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, got);
      end else begin
        exp_res = pending_results.pop_front();
        if (got.id !== exp_res.id || got.prio !== exp_res.prio ||
            got.status !== exp_res.status || got.occ !== exp_res.occ)
          report_mismatch("result mismatch", exp_res, got);
      end
    end
  end

  initial begin
    int enq_bias;
    prq_op_e op;
    logic [PRIO_BITS-1:0] pr;

    // empty queue, extreme fields, full queue, equal priorities
    dir_rows.push_back(dir_row(OP_DEQ, 0, 0, 1'b1,
                               '{id: 0, prio: 0, status: ST_EMPTY, occ: 0}));
    dir_rows.push_back(dir_row(OP_ENQ, 63, 255, 1'b1,
                               '{id: 0, prio: 0, status: ST_OK, occ: 1}));
    dir_rows.push_back(dir_row(OP_ENQ, 0, 0, 1'b1,
                               '{id: 0, prio: 0, status: ST_OK, occ: 2}));
    dir_rows.push_back(dir_row(OP_DEQ, 21, 170, 1'b1,
                               '{id: 63, prio: 255, status: ST_OK, occ: 1}));
    dir_rows.push_back(dir_row(OP_DEQ, 63, 255, 1'b1,
                               '{id: 0, prio: 0, status: ST_OK, occ: 0}));
    dir_rows.push_back(dir_row(OP_DEQ, 42, 85, 1'b1,
                               '{id: 0, prio: 0, status: ST_EMPTY, occ: 0}));
    dir_rows.push_back(dir_row(OP_ENQ, 1, 8));
    dir_rows.push_back(dir_row(OP_ENQ, 2, 8));
    dir_rows.push_back(dir_row(OP_ENQ, 3, 200));
    dir_rows.push_back(dir_row(OP_ENQ, 4, 8));
    dir_rows.push_back(dir_row(OP_ENQ, 5, 0));
    dir_rows.push_back(dir_row(OP_ENQ, 6, 255));
    dir_rows.push_back(dir_row(OP_ENQ, 7, 200));
    dir_rows.push_back(dir_row(OP_ENQ, 8, 0));
    dir_rows.push_back(dir_row(OP_ENQ, 9, 8));
    dir_rows.push_back(dir_row(OP_ENQ, 10, 128));
    dir_rows.push_back(dir_row(OP_ENQ, 11, 128));
    dir_rows.push_back(dir_row(OP_ENQ, 12, 1));
    dir_rows.push_back(dir_row(OP_ENQ, 13, 254));
    dir_rows.push_back(dir_row(OP_ENQ, 14, 8));
    dir_rows.push_back(dir_row(OP_ENQ, 15, 200));
    dir_rows.push_back(dir_row(OP_ENQ, 16, 0));
    dir_rows.push_back(dir_row(OP_ENQ, 42, 77, 1'b1,
                               '{id: 0, prio: 0, status: ST_FULL, occ: 16}));
    dir_rows.push_back(dir_row(OP_DEQ, 0, 0));

    // reset
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    enq_bias = 50;
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 17 : (ph == 1) ? 46 : 0;
      if (ph == 0) begin
        foreach (dir_rows[i])
          send_item(dir_rows[i].op, dir_rows[i].id, dir_rows[i].prio,
                    dir_rows[i].typed, dir_rows[i].res);
      end
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        // drift the enqueue share so the fill level sweeps empty to full
        if (n % 40 == 0) begin
          case ($urandom_range(3))
            0: enq_bias = 20;
            1: enq_bias = 50;
            2: enq_bias = 75;
            default: enq_bias = 95;
          endcase
        end
        op = ($urandom_range(99) < enq_bias) ? OP_ENQ : OP_DEQ;
        // narrow priority set half the time for plenty of ties
        pr = $urandom_range(1) ? PRIO_BITS'($urandom_range(255))
                               : PRIO_BITS'($urandom_range(3) * 85);
        send_item(op, ID_BITS'($urandom_range(63)), pr, 1'b0, '0);
      end
    end
    start <= 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (err_count == 0) begin
      $display("priority_ready_queue verification clean");
    end else begin
      $display("priority_ready_queue verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
